// ===== design/scl_pkg.sv =====
`timescale 1ns / 1ps

package scl_pkg;

   // result codes
   localparam logic [1:0] RT_BYTE = 2'd0;
   localparam logic [1:0] RT_END  = 2'd1;
   localparam logic [1:0] RT_OK   = 2'd2;
   localparam logic [1:0] RT_ERR  = 2'd3;

   // token kinds
   localparam logic [2:0] K_WORD    = 3'd0;
   localparam logic [2:0] K_SQUOTE  = 3'd1;
   localparam logic [2:0] K_DQUOTE  = 3'd2;
   localparam logic [2:0] K_IN      = 3'd3;
   localparam logic [2:0] K_OUT     = 3'd4;
   localparam logic [2:0] K_HEREDOC = 3'd5;
   localparam logic [2:0] K_APPEND  = 3'd6;
   localparam logic [2:0] K_PIPE    = 3'd7;

   // characters of interest
   localparam logic [7:0] CH_EOL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_PIPE   = 8'h7C;

   typedef struct packed {
      logic [1:0] rtype;
      logic [2:0] kind;
      logic [7:0] value;
      logic       last;
   } result_type;

   // all results caused by one request byte (one or two)
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   function automatic result_type make_res(logic [1:0] rtype, logic [2:0] kind,
                                           logic [7:0] value);
      result_type r;
      r.rtype = rtype;
      r.kind  = kind;
      r.value = value;
      r.last  = 1'b0;
      return r;
   endfunction

endpackage

// ===== design/scl_front.sv =====
`timescale 1ns / 1ps

module scl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_ch,
   output logic               req_stall,
   input  logic               q_full,
   output logic               push,
   output scl_pkg::entry_type push_entry
);

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_WORD = 3'd1;
   localparam logic [2:0] M_SQ   = 3'd2;
   localparam logic [2:0] M_DQ   = 3'd3;
   localparam logic [2:0] M_LT   = 3'd4;
   localparam logic [2:0] M_GT   = 3'd5;
   localparam logic [2:0] M_ERR  = 3'd6;

   logic [2:0] mode_ff, mode_in;
   logic       qne_ff, qne_in;
   logic       accept;

   // token start from a nonzero byte
   logic                st_has, st_qclr;
   logic [2:0]          st_mode;
   scl_pkg::result_type st_res;

   logic                has_a, has_c, use_st, b_has, any;
   scl_pkg::result_type res_a, res_c, b_res;
   logic [7:0]          c;
   logic [7:0]          q_ch;
   logic [2:0]          q_kind;
   logic                is_lt_gt, ends_word, is_bad;

   assign c         = req_ch;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign is_bad    = (c == scl_pkg::CH_SEMI) || (c == scl_pkg::CH_BSLASH);
   assign ends_word = is_bad || (c == scl_pkg::CH_LT) || (c == scl_pkg::CH_GT)
                   || (c == scl_pkg::CH_PIPE) || (c == scl_pkg::CH_SPACE)
                   || (c == scl_pkg::CH_DQUOTE) || (c == scl_pkg::CH_SQUOTE);

   always_comb begin
      st_has  = 1'b0;
      st_qclr = 1'b0;
      st_mode = M_IDLE;
      st_res  = scl_pkg::make_res(scl_pkg::RT_BYTE, scl_pkg::K_WORD, c);
      priority if (c == scl_pkg::CH_SPACE) begin
         st_mode = M_IDLE;
      end else if (c == scl_pkg::CH_SQUOTE) begin
         st_mode = M_SQ;
         st_qclr = 1'b1;
      end else if (c == scl_pkg::CH_DQUOTE) begin
         st_mode = M_DQ;
         st_qclr = 1'b1;
      end else if (is_bad) begin
         st_mode = M_ERR;
         st_has  = 1'b1;
         st_res  = scl_pkg::make_res(scl_pkg::RT_ERR, scl_pkg::K_WORD, 8'd0);
      end else if (c == scl_pkg::CH_LT) begin
         st_mode = M_LT;
      end else if (c == scl_pkg::CH_GT) begin
         st_mode = M_GT;
      end else if (c == scl_pkg::CH_PIPE) begin
         st_mode = M_IDLE;
         st_has  = 1'b1;
         st_res  = scl_pkg::make_res(scl_pkg::RT_END, scl_pkg::K_PIPE, 8'd0);
      end else begin
         st_mode = M_WORD;
         st_has  = 1'b1;
      end
   end

   assign q_ch     = (mode_ff == M_SQ) ? scl_pkg::CH_SQUOTE : scl_pkg::CH_DQUOTE;
   assign q_kind   = (mode_ff == M_SQ) ? scl_pkg::K_SQUOTE : scl_pkg::K_DQUOTE;
   assign is_lt_gt = (mode_ff == M_LT);

   // results: optional prefix a, then either the token-start result or suffix c
   always_comb begin
      mode_in = mode_ff;
      qne_in  = qne_ff;
      has_a   = 1'b0;
      has_c   = 1'b0;
      use_st  = 1'b0;
      res_a   = scl_pkg::make_res(scl_pkg::RT_OK, scl_pkg::K_WORD, 8'd0);
      res_c   = scl_pkg::make_res(scl_pkg::RT_OK, scl_pkg::K_WORD, 8'd0);
      unique case (mode_ff)
         M_ERR: begin
            if (c == scl_pkg::CH_EOL) mode_in = M_IDLE;
         end
         M_SQ, M_DQ: begin
            priority if (c == scl_pkg::CH_EOL) begin
               has_a   = 1'b1;
               res_a   = scl_pkg::make_res(scl_pkg::RT_ERR, scl_pkg::K_WORD, 8'd0);
               mode_in = M_IDLE;
            end else if (c == q_ch) begin
               has_a   = qne_ff;
               res_a   = scl_pkg::make_res(scl_pkg::RT_END, q_kind, 8'd0);
               qne_in  = 1'b0;
               mode_in = M_IDLE;
            end else begin
               has_a  = 1'b1;
               res_a  = scl_pkg::make_res(scl_pkg::RT_BYTE, q_kind, c);
               qne_in = 1'b1;
            end
         end
         M_WORD: begin
            priority if (c == scl_pkg::CH_EOL) begin
               has_a   = 1'b1;
               res_a   = scl_pkg::make_res(scl_pkg::RT_END, scl_pkg::K_WORD, 8'd0);
               has_c   = 1'b1;
               mode_in = M_IDLE;
            end else if (is_bad) begin
               use_st = 1'b1;
            end else if (ends_word) begin
               has_a  = 1'b1;
               res_a  = scl_pkg::make_res(scl_pkg::RT_END, scl_pkg::K_WORD, 8'd0);
               use_st = 1'b1;
            end else begin
               has_a = 1'b1;
               res_a = scl_pkg::make_res(scl_pkg::RT_BYTE, scl_pkg::K_WORD, c);
            end
         end
         M_LT, M_GT: begin
            priority if (c == (is_lt_gt ? scl_pkg::CH_LT : scl_pkg::CH_GT)) begin
               has_a   = 1'b1;
               res_a   = scl_pkg::make_res(scl_pkg::RT_END,
                            is_lt_gt ? scl_pkg::K_HEREDOC : scl_pkg::K_APPEND, 8'd0);
               mode_in = M_IDLE;
            end else if (is_bad) begin
               use_st = 1'b1;
            end else begin
               has_a = 1'b1;
               res_a = scl_pkg::make_res(scl_pkg::RT_END,
                          is_lt_gt ? scl_pkg::K_IN : scl_pkg::K_OUT, 8'd0);
               if (c == scl_pkg::CH_EOL) begin
                  has_c   = 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  use_st = 1'b1;
               end
            end
         end
         default: begin
            // idle, and the unused code behaves as idle
            mode_in = M_IDLE;
            if (c == scl_pkg::CH_EOL) has_c  = 1'b1;
            else                      use_st = 1'b1;
         end
      endcase
      if (use_st) begin
         mode_in = st_mode;
         if (st_qclr) qne_in = 1'b0;
      end
   end

   assign b_has = use_st ? st_has : has_c;
   assign b_res = use_st ? st_res : res_c;
   assign any   = has_a || b_has;

   always_comb begin
      push_entry.two = has_a && b_has;
      push_entry.r0  = has_a ? res_a : b_res;
      push_entry.r1  = b_res;
      if (has_a && b_has) push_entry.r1.last = 1'b1;
      else                push_entry.r0.last = 1'b1;
   end

   assign push = accept && any;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         qne_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         qne_ff  <= qne_in;
      end
   end

endmodule

// ===== design/scl_queue.sv =====
`timescale 1ns / 1ps

module scl_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  scl_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output scl_pkg::entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   scl_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   assign wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop)  rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
`endif

endmodule

// ===== design/scl_back.sv =====
`timescale 1ns / 1ps

module scl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  scl_pkg::entry_type q_head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output scl_pkg::result_type rsp_res
);

   logic                out_valid_ff, out_valid_in;
   logic                sec_valid_ff, sec_valid_in;
   scl_pkg::result_type out_ff, out_in;
   scl_pkg::result_type sec_ff, sec_in;
   logic                taken;

   assign taken = out_valid_ff && !rsp_stall;
   assign pop   = q_not_empty && (!out_valid_ff || (taken && !sec_valid_ff));

   always_comb begin
      out_valid_in = out_valid_ff;
      sec_valid_in = sec_valid_ff;
      out_in       = out_ff;
      sec_in       = sec_ff;
      if (taken && sec_valid_ff) begin
         out_in       = sec_ff;
         sec_valid_in = 1'b0;
      end else if (pop) begin
         out_valid_in = 1'b1;
         out_in       = q_head.r0;
         sec_in       = q_head.r1;
         sec_valid_in = q_head.two;
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_ff;

`ifndef SYNTHESIS
   a_sec_needs_out: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> out_valid_ff) else $error("second result without first");
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && sec_valid_ff) |-> !out_ff.last)
      else $error("last flag set ahead of pending result");
`endif

endmodule

// ===== design/shell_command_lexer.sv =====
`timescale 1ns / 1ps

// Command-line lexer. Feed one byte per request on req_ch; a zero byte ends
// the line. Each result is a token byte, a token end with its kind, line ok or
// line error, and rsp_last marks the final result caused by a request byte.
// A byte is accepted every cycle while the result queue (QUEUE_DEPTH entries,
// one entry per byte that gives any result) has room; a result goes through the
// queue and the output register. The response port gives one result per cycle
// while rsp_stall is low, so a byte that gives two results (e.g. a word end
// followed by an operator or line ok) sends both in turn; input runs at one byte
// per cycle when each byte gives at most one result and rsp_stall is low. After
// a line error the rest of the line is swallowed silently up to its ending zero.
module shell_command_lexer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_rtype,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic       rsp_last
);

   logic                q_full, q_push, q_pop, q_not_empty;
   scl_pkg::entry_type  q_in, q_head;
   scl_pkg::result_type res;

   // front: lexer state machine, classifies each request byte
   scl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ch     (req_ch),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .push       (q_push),
      .push_entry (q_in)
   );

   // queue decouples lexing from result delivery
   scl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // back: serializes one or two results per entry onto the response port
   scl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_res     (res)
   );

   assign rsp_rtype = res.rtype;
   assign rsp_kind  = res.kind;
   assign rsp_value = res.value;
   assign rsp_last  = res.last;

endmodule
